[rtl/adts_pkg.sv]
// shared types and constants for the adts frame deframer
// used by adts_parser, adts_out_stage and adts_frame_deframer; no dependencies
package adts_pkg;

  localparam int unsigned HeaderBytesDef = 7;
  localparam int unsigned LenW           = 13;

  localparam logic [7:0] SyncByte   = 8'hff;
  localparam logic [3:0] SyncNibble = 4'hf;

  typedef enum logic [1:0] {
    ST_HUNT = 2'd0,
    ST_HEAD = 2'd1,
    ST_BODY = 2'd2,
    ST_EMIT = 2'd3
  } state_e;

  typedef struct packed {
    logic [7:0]      data;
    logic            first;
    logic            last;
    logic [LenW-1:0] length;
    logic [1:0]      profile;
    logic [3:0]      rate;
    logic            trunc;
  } res_t;

endpackage

[rtl/adts_parser.sv]
// sync hunt, header capture and frame byte sequencing for the adts deframer
// depends on adts_pkg; feeds adts_out_stage
module adts_parser #(
  parameter int unsigned HEADER_BYTES = adts_pkg::HeaderBytesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       in_byte_i,
  input  logic             in_end_i,
  input  logic             can_take_i,
  output logic             res_valid_o,
  output adts_pkg::res_t   res_o
);

  localparam int unsigned IdxW = $clog2(HEADER_BYTES);
  localparam logic [adts_pkg::LenW-1:0] HdrLen = adts_pkg::LenW'(HEADER_BYTES);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(HEADER_BYTES - 1);

  adts_pkg::state_e           state_q, state_d;
  logic [7:0]                 prev_q, prev_d;
  logic [adts_pkg::LenW-1:0]  count_q, count_d;
  logic [adts_pkg::LenW-1:0]  len_held_q, len_held_d;
  logic                       end_q, end_d;
  logic [IdxW-1:0]            idx_q, idx_d;
  logic [7:0]                 store_q [HEADER_BYTES];

  logic                       accept;
  logic                       wr_sync, wr_head;
  logic [IdxW-1:0]            head_idx;
  logic [adts_pkg::LenW-1:0]  cnt_inc;
  logic [adts_pkg::LenW-1:0]  hdr_len;
  logic                       fin, done, cut;

  assign in_ready_o = can_take_i && (state_q != adts_pkg::ST_EMIT);
  assign accept     = in_valid_i && in_ready_o;
  assign head_idx   = count_q[IdxW-1:0];
  assign cnt_inc    = count_q + adts_pkg::LenW'(1);
  assign hdr_len    = {store_q[3][1:0], store_q[4], store_q[5][7:5]};

  always_comb begin
    state_d    = state_q;
    prev_d     = prev_q;
    count_d    = count_q;
    len_held_d = len_held_q;
    end_d      = end_q;
    idx_d      = idx_q;
    wr_sync    = 1'b0;
    wr_head    = 1'b0;
    fin        = 1'b0;
    done       = 1'b0;
    cut        = 1'b0;
    res_valid_o   = 1'b0;
    res_o.data    = in_byte_i;
    res_o.first   = 1'b0;
    res_o.last    = 1'b0;
    res_o.length  = len_held_q;
    res_o.profile = store_q[2][7:6];
    res_o.rate    = store_q[2][5:2];
    res_o.trunc   = 1'b0;
    case (state_q)
      adts_pkg::ST_HEAD: begin
        if (accept) begin
          wr_head = 1'b1;
          count_d = cnt_inc;
          if (cnt_inc < HdrLen) begin
            if (in_end_i) begin
              state_d = adts_pkg::ST_HUNT;
              prev_d  = 8'h00;
              count_d = '0;
            end
          end else if (hdr_len < HdrLen) begin
            // bogus length, drop header and resume the hunt
            state_d = adts_pkg::ST_HUNT;
            prev_d  = in_end_i ? 8'h00 : in_byte_i;
            count_d = '0;
          end else begin
            state_d    = adts_pkg::ST_EMIT;
            idx_d      = '0;
            end_d      = in_end_i;
            len_held_d = hdr_len;
          end
        end
      end
      adts_pkg::ST_EMIT: begin
        fin  = (idx_q == LastIdx);
        done = fin && (len_held_q == HdrLen);
        cut  = fin && !done && end_q;
        res_o.data  = store_q[idx_q];
        res_o.first = (idx_q == '0);
        res_o.last  = done || cut;
        res_o.trunc = cut;
        if (can_take_i) begin
          res_valid_o = 1'b1;
          idx_d       = idx_q + IdxW'(1);
          if (fin) begin
            if (done || end_q) begin
              state_d = adts_pkg::ST_HUNT;
              prev_d  = 8'h00;
              count_d = '0;
            end else begin
              state_d = adts_pkg::ST_BODY;
              count_d = HdrLen;
            end
          end
        end
      end
      adts_pkg::ST_BODY: begin
        done        = (cnt_inc >= len_held_q);
        res_o.last  = done || in_end_i;
        res_o.trunc = !done && in_end_i;
        if (accept) begin
          res_valid_o = 1'b1;
          count_d     = cnt_inc;
          if (done || in_end_i) begin
            state_d = adts_pkg::ST_HUNT;
            prev_d  = 8'h00;
            count_d = '0;
          end
        end
      end
      default: begin
        if (accept) begin
          if (prev_q == adts_pkg::SyncByte && in_byte_i[7:4] == adts_pkg::SyncNibble) begin
            wr_sync = 1'b1;
            if (in_end_i) begin
              state_d = adts_pkg::ST_HUNT;
              prev_d  = 8'h00;
              count_d = '0;
            end else begin
              state_d = adts_pkg::ST_HEAD;
              count_d = adts_pkg::LenW'(2);
            end
          end else begin
            state_d = adts_pkg::ST_HUNT;
            prev_d  = in_end_i ? 8'h00 : in_byte_i;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= adts_pkg::ST_HUNT;
      prev_q     <= 8'h00;
      count_q    <= '0;
      len_held_q <= '0;
      end_q      <= 1'b0;
      idx_q      <= '0;
    end else begin
      state_q    <= state_d;
      prev_q     <= prev_d;
      count_q    <= count_d;
      len_held_q <= len_held_d;
      end_q      <= end_d;
      idx_q      <= idx_d;
    end
  end

  // header store holds no reset, every entry is written before it is read
  always_ff @(posedge clk_i) begin
    if (wr_sync) begin
      store_q[0] <= adts_pkg::SyncByte;
      store_q[1] <= in_byte_i;
    end
    if (wr_head) begin
      store_q[head_idx] <= in_byte_i;
    end
  end

  a_emit_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == adts_pkg::ST_EMIT |-> !in_ready_o)
    else $error("input taken during header burst");

  a_first_is_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.first |-> res_o.data == adts_pkg::SyncByte)
    else $error("frame does not start with sync byte");

  a_body_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == adts_pkg::ST_BODY |-> count_q < len_held_q && len_held_q > HdrLen)
    else $error("body count out of range");

  a_trunc_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.trunc |-> res_o.last)
    else $error("truncated beat not marked last");

endmodule

[rtl/adts_out_stage.sv]
// output register with skid entry for the adts deframer result stream
// depends on adts_pkg
module adts_out_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  adts_pkg::res_t push_res_i,
  output logic           can_take_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output adts_pkg::res_t out_res_o
);

  logic           out_valid_q, out_valid_d;
  logic           skid_valid_q, skid_valid_d;
  adts_pkg::res_t out_q, out_d;
  adts_pkg::res_t skid_q, skid_d;
  logic           pop;

  assign pop         = out_valid_q && out_ready_i;
  assign can_take_o  = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || pop) begin
        out_d       = push_res_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = push_res_i;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid full while output empty");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> !push_i)
    else $error("push into full output stage");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i && push_i |=> skid_valid_q)
    else $error("stalled push lost");

endmodule

[rtl/adts_frame_deframer.sv]
// a body beat taken on s_axis is registered in the output stage before it appears on m_axis
// throughput unless the output stage is full: one byte per cycle; a valid header's last byte
//   starts a burst of HEADER_BYTES header beats, one per cycle, with s_axis_tready held low
// a two-entry output stage keeps input flowing while one result waits downstream
// reset: async active low, returns to sync hunt; the header store is not reset
// top level, uses adts_pkg, adts_parser and adts_out_stage
module adts_frame_deframer #(
  parameter int unsigned HEADER_BYTES = adts_pkg::HeaderBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tlast,   // buffer_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // out_byte, frame_length, profile, rate_index, zero pad
  output logic [1:0]  m_axis_tuser,   // frame_first, truncated
  output logic        m_axis_tlast    // frame_last
);

  logic           can_take;
  logic           res_valid;
  adts_pkg::res_t res;
  adts_pkg::res_t out_res;

  adts_parser #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_end_i    (s_axis_tlast),
    .can_take_i  (can_take),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  adts_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_res_i  (res),
    .can_take_o  (can_take),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (out_res)
  );

  assign m_axis_tdata = {5'b0, out_res.rate, out_res.profile, out_res.length, out_res.data};
  assign m_axis_tuser = {out_res.trunc, out_res.first};
  assign m_axis_tlast = out_res.last;

endmodule

[bench/adts_frame_deframer_tb.sv]
// testbench for adts_frame_deframer: drives adts byte streams and checks every output beat
// against a cycle-free predictor; needs adts_pkg and the deframer rtl
`timescale 1ns / 1ps

module adts_frame_deframer_tb;

  localparam int unsigned HdrLen = adts_pkg::HeaderBytesDef;

  // predicts the beats of the deframer and checks them in order
  class adts_frame_board;
    adts_pkg::state_e phase;
    logic [7:0]       prev_byte;
    logic [7:0]       hdr [HdrLen];
    logic [12:0]      count;
    logic [12:0]      held_len;
    adts_pkg::res_t   beats_due[$];
    int               mismatches;

    function new();
      phase      = adts_pkg::ST_HUNT;
      prev_byte  = 8'h00;
      count      = '0;
      held_len   = '0;
      mismatches = 0;
    endfunction

    function void back_to_hunt(logic [7:0] keep);
      phase     = adts_pkg::ST_HUNT;
      prev_byte = keep;
      count     = '0;
    endfunction

    function void push_beat(logic [7:0] b, logic first, logic last, logic [12:0] len,
                            logic trunc);
      adts_pkg::res_t r;
      r.data    = b;
      r.first   = first;
      r.last    = last;
      r.length  = len;
      r.profile = hdr[2][7:6];
      r.rate    = hdr[2][5:2];
      r.trunc   = trunc;
      beats_due.push_back(r);
    endfunction

    // one accepted input beat
    function void take_byte(logic [7:0] b, logic fin);
      logic [12:0] len;
      logic        done;
      logic        cut;
      case (phase)
        adts_pkg::ST_HEAD: begin
          hdr[count] = b;
          count = count + 13'd1;
          if (count < HdrLen) begin
            if (fin) back_to_hunt(8'h00);
          end else begin
            len = {hdr[3][1:0], hdr[4], hdr[5][7:5]};
            if (len < HdrLen) begin
              // too short: drop the header, last byte may start a new sync
              back_to_hunt(fin ? 8'h00 : b);
            end else begin
              for (int i = 0; i < HdrLen; i++) begin
                done = (i == HdrLen - 1) && (len == HdrLen);
                cut  = (i == HdrLen - 1) && !done && fin;
                push_beat(hdr[i], i == 0, done || cut, len, cut);
              end
              if (len == HdrLen || fin) begin
                back_to_hunt(8'h00);
              end else begin
                phase    = adts_pkg::ST_BODY;
                count    = HdrLen;
                held_len = len;
              end
            end
          end
        end
        adts_pkg::ST_BODY: begin
          count = count + 13'd1;
          done  = count >= held_len;
          push_beat(b, 1'b0, done || fin, held_len, !done && fin);
          if (done || fin) back_to_hunt(8'h00);
        end
        default: begin
          if (prev_byte == adts_pkg::SyncByte && b[7:4] == adts_pkg::SyncNibble) begin
            hdr[0] = adts_pkg::SyncByte;
            hdr[1] = b;
            if (fin) begin
              back_to_hunt(8'h00);
            end else begin
              phase = adts_pkg::ST_HEAD;
              count = 13'd2;
            end
          end else begin
            phase     = adts_pkg::ST_HUNT;
            prev_byte = fin ? 8'h00 : b;
          end
        end
      endcase
    endfunction

    function void field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void match_beat(adts_pkg::res_t got);
      adts_pkg::res_t want;
      if (beats_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected beat, expected none, actual %p", $time, got);
        return;
      end
      want = beats_due.pop_front();
      field("out_byte", want.data, got.data);
      field("frame_first", want.first, got.first);
      field("frame_last", want.last, got.last);
      field("frame_length", want.length, got.length);
      field("profile", want.profile, got.profile);
      field("rate_index", want.rate, got.rate);
      field("truncated", want.trunc, got.trunc);
    endfunction

    function int pending();
      return beats_due.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // data_byte
  logic        s_axis_tlast = 1'b0;    // buffer_end
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // out_byte, frame_length, profile, rate_index, zero pad
  logic [1:0]  m_axis_tuser;           // frame_first, truncated
  logic        m_axis_tlast;           // frame_last

  adts_frame_board board = new();
  bit steady   = 1'b0;   // no idling on either side while set
  bit hold_req = 1'b0;   // asks the receiver for one long hold-off
  int frame_bytes_sent;

  adts_frame_deframer DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit idle_now();
    return !steady && ($urandom_range(0, 99) < 10);
  endfunction

  // offer one beat and wait until it is taken
  task automatic send_byte(input logic [7:0] d, input logic fin);
    while (idle_now()) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= fin;
    do @(posedge clk_i); while (!s_axis_tready);
    board.take_byte(d, fin);
  endtask

  // one frame with random content; cut marks the byte carrying buffer_end, -1 for none
  task automatic send_frame(input int len, input int cut, input logic [7:0] b2,
                            input bit bad_sync);
    logic [7:0]  hdr [HdrLen];
    logic [12:0] ln;
    int          total;
    ln     = len[12:0];
    hdr[0] = adts_pkg::SyncByte;
    hdr[1] = bad_sync ? 8'($urandom_range(0, 8'hef)) : {adts_pkg::SyncNibble, 4'($urandom)};
    hdr[2] = b2;
    hdr[3] = {6'($urandom), ln[12:11]};
    hdr[4] = ln[10:3];
    hdr[5] = {ln[2:0], 5'($urandom)};
    hdr[6] = 8'($urandom);
    total  = (len < HdrLen) ? HdrLen : len;
    for (int i = 0; i < total; i++) begin
      send_byte((i < HdrLen) ? hdr[i] : 8'($urandom), i == cut);
      if (!bad_sync) frame_bytes_sent++;
      if (i == cut) break;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (300) @(negedge clk_i);
      end else begin
        m_axis_tready <= !idle_now();
      end
    end
  end

  always @(posedge clk_i) begin : watch_out
    adts_pkg::res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.data    = m_axis_tdata[7:0];
      got.length  = m_axis_tdata[20:8];
      got.profile = m_axis_tdata[22:21];
      got.rate    = m_axis_tdata[26:23];
      got.first   = m_axis_tuser[0];
      got.trunc   = m_axis_tuser[1];
      got.last    = m_axis_tlast;
      board.match_beat(got);
    end
  end

  initial begin
    #2000000;
    $display("adts_frame_deframer_tb: errors");
    $finish;
  end

  initial begin
    int len;
    int cut;
    int nframe;
    frame_bytes_sent = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // header-only frame, profile 3 and rate 15
    send_frame(HdrLen, -1, 8'hff, 1'b0);
    // zero length dropped; its last byte 0xff pairs with the next byte as a new sync
    send_byte(8'hff, 1'b0);
    send_byte(8'hf1, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    // max length, cut by buffer_end on the last header byte
    send_byte(8'hf0, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'he0, 1'b0);
    send_byte(8'h5a, 1'b1);
    // buffer end inside a partial header
    send_byte(8'hff, 1'b0);
    send_byte(8'hf9, 1'b0);
    send_byte(8'h12, 1'b1);
    // buffer end in the hunt, no sync across the boundary
    send_byte(8'hff, 1'b1);
    send_byte(8'hf0, 1'b0);
    wait_drained();

    frame_bytes_sent = 0;
    nframe = 0;
    while (frame_bytes_sent < 220) begin
      // early frames always run, so the hold-off and the gap-free stretch always happen
      steady = (nframe >= 1 && nframe < 5);
      if (nframe == 0) hold_req = 1'b1;
      if (nframe == 18) wait_drained();

      // noise between frames
      if ($urandom_range(0, 99) < 20) begin
        repeat ($urandom_range(1, 4))
          send_byte(8'($urandom_range(0, 254)), $urandom_range(0, 99) < 3);
      end

      case ($urandom_range(0, 19))
        0, 1:    len = $urandom_range(0, HdrLen - 1);
        2, 3:    len = $urandom_range(31, 120);
        4:       len = $urandom_range(121, 8191);
        default: len = $urandom_range(HdrLen, 30);
      endcase
      if (len > 120)
        cut = $urandom_range(HdrLen, HdrLen + 20);
      else if ($urandom_range(0, 9) == 0)
        cut = $urandom_range(0, ((len < HdrLen) ? HdrLen : len) - 1);
      else
        cut = -1;
      send_frame(len, cut, 8'($urandom), $urandom_range(0, 9) == 0);
      nframe++;
    end
    steady = 1'b0;

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("adts_frame_deframer_tb: clean");
    end else begin
      $display("adts_frame_deframer_tb: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/adts_pkg.sv
rtl/adts_parser.sv
rtl/adts_out_stage.sv
rtl/adts_frame_deframer.sv
bench/adts_frame_deframer_tb.sv
